// File: rtl/sirt_pkg.sv
// shared constants, types and a conversion helper for the interval table
`timescale 1ns / 1ps
package sirt_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 16;

    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // fixed field widths of the channels
    localparam int FIELD_TIME_BITS = 16;
    localparam int SLOT_BITS       = 4;
    localparam int HELD_BITS       = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [1:0] OUT_OK        = 2'd0;
    localparam logic [1:0] OUT_OVERLAP   = 2'd1;
    localparam logic [1:0] OUT_FULL      = 2'd2;
    localparam logic [1:0] OUT_NOT_FOUND = 2'd3;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        time_t start;
        time_t finish;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic  action;
        time_t start;
        time_t finish;
        logic  commit;
    } cell_ctl_t;

    // per cell result of the compare pass
    typedef struct packed {
        logic found_out;
        logic stop;
        logic ovl;
        logic bad;
    } cell_stat_t;

    function automatic time_t to_time(input logic [FIELD_TIME_BITS-1:0] x);
        return TIME_BITS'(x);
    endfunction

endpackage

// File: rtl/sirt_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface sirt_req_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     action;
    logic [sirt_pkg::FIELD_TIME_BITS-1:0]     begin_time;
    logic [sirt_pkg::FIELD_TIME_BITS-1:0]     end_time;

    modport source (output valid, action, begin_time, end_time, input ready);
    modport sink   (input valid, action, begin_time, end_time, output ready);
endinterface

interface sirt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      outcome;
    logic [sirt_pkg::SLOT_BITS-1:0]  slot;
    logic [sirt_pkg::HELD_BITS-1:0]  entries_held;

    modport source (output valid, outcome, slot, entries_held, input ready);
    modport sink   (input valid, outcome, slot, entries_held, output ready);
endinterface

// File: rtl/sorted_interval_reservation_table_unit.sv
// sorted non-overlapping interval table built from a row of shifting cells
// a request is captured on its transaction and its result is registered at the end of the
//   execute state, later only while a previous result still waits in the result register
// no new request is taken before the execute state ends, in which every cell compares against
//   the request and shifts in the same edge
// reset: occupancy, control state and the result valid flag clear at once;
//   the interval store is not cleared and needs no clearing pass
`timescale 1ns / 1ps
module sorted_interval_reservation_table_unit (
    input  logic       clk,
    input  logic       rst_n,
    sirt_req_if.sink   req,
    sirt_rsp_if.source rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam int D = sirt_pkg::DEPTH;

    logic                          state_reg;
    logic                          state_next;
    logic                          action_reg;
    sirt_pkg::time_t               start_reg;
    sirt_pkg::time_t               finish_reg;
    logic [sirt_pkg::CNT_BITS-1:0] occ_reg;
    logic [sirt_pkg::CNT_BITS-1:0] occ_next;

    logic                          out_valid_reg;
    logic [1:0]                    out_outcome_reg;
    logic [sirt_pkg::SLOT_BITS-1:0] out_slot_reg;
    logic [sirt_pkg::HELD_BITS-1:0] out_held_reg;

    sirt_pkg::cell_ctl_t           ctl;
    sirt_pkg::entry_t              entries [D];
    sirt_pkg::cell_stat_t          stats   [D];
    logic [D:0]                    found;

    logic                          full;
    logic                          overlap;
    logic                          any_hit;
    logic [1:0]                    outcome;
    logic [sirt_pkg::IDX_BITS-1:0] pos;
    logic                          exec_done;
    logic                          commit;

    assign req.ready = (state_reg == ST_IDLE);

    assign ctl.action = action_reg;
    assign ctl.start  = start_reg;
    assign ctl.finish = finish_reg;
    assign ctl.commit = commit;

    assign found[0] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < D; k++)
        begin : g_cell
            sirt_pkg::entry_t lower;
            sirt_pkg::entry_t upper;
            logic             lower_ovl;
            logic             valid;

            assign valid = (sirt_pkg::CNT_BITS'(k) < occ_reg);

            if (k == 0)
            begin : g_first
                assign lower     = '0;
                assign lower_ovl = 1'b0;
            end
            else
            begin : g_mid
                assign lower     = entries[k-1];
                assign lower_ovl = stats[k-1].ovl;
            end

            if (k == D - 1)
            begin : g_last
                assign upper = '0;
            end
            else
            begin : g_up
                assign upper = entries[k+1];
            end

            sirt_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .valid     (valid),
                .found_in  (found[k]),
                .lower_ovl (lower_ovl),
                .lower     (lower),
                .upper     (upper),
                .entry     (entries[k]),
                .stat      (stats[k])
            );

            assign found[k+1] = stats[k].found_out;
        end
    endgenerate

    always_comb
    begin
        overlap = 1'b0;
        pos     = '0;
        for (int i = 0; i < D; i++)
        begin
            overlap = overlap | stats[i].bad;
            if (stats[i].stop)
            begin
                pos = pos | sirt_pkg::IDX_BITS'(i);
            end
        end
    end

    assign full    = (occ_reg == sirt_pkg::CNT_BITS'(D));
    assign any_hit = found[D];

    always_comb
    begin
        if (action_reg == sirt_pkg::ACT_INSERT)
        begin
            if (full)
                outcome = sirt_pkg::OUT_FULL;
            else if (overlap)
                outcome = sirt_pkg::OUT_OVERLAP;
            else
                outcome = sirt_pkg::OUT_OK;
        end
        else
        begin
            outcome = any_hit ? sirt_pkg::OUT_OK : sirt_pkg::OUT_NOT_FOUND;
        end
    end

    // execute only when the result register is free or being emptied
    assign exec_done = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);
    assign commit    = exec_done && (outcome == sirt_pkg::OUT_OK);

    always_comb
    begin
        occ_next = occ_reg;
        if (commit)
        begin
            if (action_reg == sirt_pkg::ACT_INSERT)
                occ_next = occ_reg + sirt_pkg::CNT_BITS'(1);
            else
                occ_next = occ_reg - sirt_pkg::CNT_BITS'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (exec_done)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            action_reg <= req.action;
            start_reg  <= sirt_pkg::to_time(req.begin_time);
            finish_reg <= sirt_pkg::to_time(req.end_time);
        end
        if (exec_done)
        begin
            out_outcome_reg <= outcome;
            out_slot_reg    <= (outcome == sirt_pkg::OUT_OK) ?
                               sirt_pkg::SLOT_BITS'(pos) : '0;
            out_held_reg    <= sirt_pkg::HELD_BITS'(occ_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.outcome      = out_outcome_reg;
    assign rsp.slot         = out_slot_reg;
    assign rsp.entries_held = out_held_reg;

endmodule

// File: rtl/sirt_cell.sv
// one table cell: holds an interval, compares it and shifts with its neighbors
`timescale 1ns / 1ps
module sirt_cell (
    input  logic                clk,
    input  sirt_pkg::cell_ctl_t ctl,
    input  logic                valid,
    input  logic                found_in,
    input  logic                lower_ovl,
    input  sirt_pkg::entry_t    lower,
    input  sirt_pkg::entry_t    upper,
    output sirt_pkg::entry_t    entry,
    output sirt_pkg::cell_stat_t stat
);

    sirt_pkg::entry_t entry_reg;
    sirt_pkg::entry_t entry_next;
    logic             gt;
    logic             match;
    logic             hit;
    logic             stop;

    assign gt    = valid && (ctl.finish > entry_reg.start);
    assign match = valid && (entry_reg.start == ctl.start);
    // insert stops at the first entry not before the new end
    assign hit   = (ctl.action == sirt_pkg::ACT_INSERT) ? !gt : match;
    assign stop  = !found_in && hit;

    assign stat.stop      = stop;
    assign stat.found_out = found_in || stop;
    assign stat.ovl       = entry_reg.finish > ctl.start;
    assign stat.bad       = stop && lower_ovl;

    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.commit)
        begin
            if (ctl.action == sirt_pkg::ACT_INSERT)
            begin
                if (found_in)
                begin
                    entry_next = lower;
                end
                else if (stop)
                begin
                    entry_next.start  = ctl.start;
                    entry_next.finish = ctl.finish;
                end
            end
            else if (found_in || stop)
            begin
                // close the gap from above
                entry_next = upper;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: dv/tb.sv
// self-checking testbench for the sorted interval reservation table unit
`timescale 1ns / 1ps
module tb;

    localparam int RANDOM_OPS   = 1800;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 16;

    typedef logic [sirt_pkg::FIELD_TIME_BITS-1:0] tick_t;

    typedef struct packed {
        logic [1:0]                     outcome;
        logic [sirt_pkg::SLOT_BITS-1:0] slot;
        logic [sirt_pkg::HELD_BITS-1:0] held;
    } reply_t;

    typedef struct {
        logic   action;
        tick_t  start;
        tick_t  stop;
        bit     typed;
        reply_t want;
    } op_t;

    logic clk = 1'b0;
    logic rst_n;

    sirt_req_if req ();
    sirt_rsp_if rsp ();

    sorted_interval_reservation_table_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow copy of the interval table
    sirt_pkg::time_t tbl_start  [sirt_pkg::DEPTH];
    sirt_pkg::time_t tbl_finish [sirt_pkg::DEPTH];
    int              tbl_count;

    reply_t pending_replies [$];
    op_t    directed_rows [$];
    int     errors      = 0;
    int     idle_cycles = 0;
    int     burst_left  = 0;
    int     ready_mode  = 0;
    int     ready_left  = 0;

    function automatic reply_t reserve_or_release(input logic action, input tick_t b_in,
                                                  input tick_t e_in);
        sirt_pkg::time_t b;
        sirt_pkg::time_t e;
        int              pos;
        reply_t          r;
        b = sirt_pkg::TIME_BITS'(b_in);
        e = sirt_pkg::TIME_BITS'(e_in);
        pos = 0;
        r.outcome = sirt_pkg::OUT_OK;
        r.slot = '0;
        if (action == sirt_pkg::ACT_INSERT)
        begin
            if (tbl_count >= sirt_pkg::DEPTH)
                r.outcome = sirt_pkg::OUT_FULL;
            else
            begin
                while (pos < tbl_count && e > tbl_start[pos])
                    pos++;
                if (pos > 0 && tbl_finish[pos-1] > b)
                    r.outcome = sirt_pkg::OUT_OVERLAP;
                else
                begin
                    for (int k = tbl_count; k > pos; k--)
                    begin
                        tbl_start[k]  = tbl_start[k-1];
                        tbl_finish[k] = tbl_finish[k-1];
                    end
                    tbl_start[pos]  = b;
                    tbl_finish[pos] = e;
                    tbl_count++;
                    r.slot = sirt_pkg::SLOT_BITS'(pos);
                end
            end
        end
        else
        begin
            while (pos < tbl_count && tbl_start[pos] != b)
                pos++;
            if (pos >= tbl_count)
                r.outcome = sirt_pkg::OUT_NOT_FOUND;
            else
            begin
                for (int k = pos; k + 1 < tbl_count; k++)
                begin
                    tbl_start[k]  = tbl_start[k+1];
                    tbl_finish[k] = tbl_finish[k+1];
                end
                tbl_count--;
                r.slot = sirt_pkg::SLOT_BITS'(pos);
            end
        end
        r.held = sirt_pkg::HELD_BITS'(tbl_count);
        return r;
    endfunction

    // mostly well-formed traffic: gap inserts, inserts near stored intervals and removes of stored begins
    function automatic op_t random_op(input int insert_pct);
        op_t o;
        int  p;
        int  lo;
        int  hi;
        int  bb;
        int  ee;
        o.typed = 1'b0;
        o.want = '0;
        if ($urandom_range(0, 99) < 8)
        begin
            o.action = 1'($urandom);
            o.start  = tick_t'($urandom);
            o.stop   = tick_t'($urandom);
        end
        else if ($urandom_range(0, 99) < insert_pct)
        begin
            o.action = sirt_pkg::ACT_INSERT;
            if (tbl_count == 0 || $urandom_range(0, 3) != 0)
            begin
                p  = $urandom_range(0, tbl_count);
                lo = (p == 0) ? 0 : int'(tbl_finish[p-1]);
                hi = (p == tbl_count) ? 65535 : int'(tbl_start[p]);
                if (lo > hi)
                begin
                    bb = lo;
                    lo = hi;
                    hi = bb;
                end
                case ($urandom_range(0, 9))
                    0:
                    begin
                        bb = hi;
                        ee = hi;
                    end
                    1:
                    begin
                        bb = lo;
                        ee = lo;
                    end
                    default:
                    begin
                        bb = $urandom_range(lo, hi);
                        ee = $urandom_range(bb, hi);
                    end
                endcase
            end
            else
            begin
                // land on or near a stored interval
                p  = $urandom_range(0, tbl_count - 1);
                bb = int'(tbl_start[p]) + $urandom_range(0, 40);
                ee = bb + $urandom_range(0, 400);
            end
            o.start = tick_t'(bb);
            o.stop  = tick_t'(ee);
        end
        else
        begin
            o.action = sirt_pkg::ACT_REMOVE;
            o.stop   = tick_t'($urandom);
            if (tbl_count > 0 && $urandom_range(0, 4) != 0)
                o.start = tbl_start[$urandom_range(0, tbl_count - 1)];
            else
                o.start = tick_t'($urandom);
        end
        return o;
    endfunction

    task automatic add_row(input logic action, input int b, input int e, input bit typed,
                           input logic [1:0] outcome, input int slot, input int held);
        op_t o;
        o.action       = action;
        o.start        = tick_t'(b);
        o.stop         = tick_t'(e);
        o.typed        = typed;
        o.want.outcome = outcome;
        o.want.slot    = sirt_pkg::SLOT_BITS'(slot);
        o.want.held    = sirt_pkg::HELD_BITS'(held);
        directed_rows.push_back(o);
    endtask

    task automatic load_directed();
        add_row(sirt_pkg::ACT_REMOVE, 0, 0, 1'b1, sirt_pkg::OUT_NOT_FOUND, 0, 0);
        add_row(sirt_pkg::ACT_INSERT, 100, 200, 1'b1, sirt_pkg::OUT_OK, 0, 1);
        // zero length at slot zero pushes the stored entry up
        add_row(sirt_pkg::ACT_INSERT, 0, 0, 1'b1, sirt_pkg::OUT_OK, 0, 2);
        add_row(sirt_pkg::ACT_INSERT, 150, 300, 1'b1, sirt_pkg::OUT_OVERLAP, 0, 2);
        add_row(sirt_pkg::ACT_INSERT, 65535, 65535, 1'b1, sirt_pkg::OUT_OK, 2, 3);
        // begin after end is placed like any other
        add_row(sirt_pkg::ACT_INSERT, 500, 400, 1'b0, sirt_pkg::OUT_OK, 0, 0);
        add_row(sirt_pkg::ACT_REMOVE, 100, 65535, 1'b0, sirt_pkg::OUT_OK, 0, 0);
        for (int k = 0; k < 13; k++)
            add_row(sirt_pkg::ACT_INSERT, 1000 + 20 * k, 1010 + 20 * k, 1'b0,
                    sirt_pkg::OUT_OK, 0, 0);
        add_row(sirt_pkg::ACT_INSERT, 2, 3, 1'b1, sirt_pkg::OUT_FULL, 0, 16);
        add_row(sirt_pkg::ACT_REMOVE, 0, 0, 1'b0, sirt_pkg::OUT_OK, 0, 0);
        add_row(sirt_pkg::ACT_REMOVE, 65535, 0, 1'b0, sirt_pkg::OUT_OK, 0, 0);
        // duplicate begins, remove takes the lowest slot
        add_row(sirt_pkg::ACT_INSERT, 5, 5, 1'b0, sirt_pkg::OUT_OK, 0, 0);
        add_row(sirt_pkg::ACT_INSERT, 5, 5, 1'b0, sirt_pkg::OUT_OK, 0, 0);
        add_row(sirt_pkg::ACT_REMOVE, 5, 0, 1'b0, sirt_pkg::OUT_OK, 0, 0);
    endtask

    // bursts of back-to-back transactions separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_op(input op_t o);
        reply_t r;
        req.valid      <= 1'b1;
        req.action     <= o.action;
        req.begin_time <= o.start;
        req.end_time   <= o.stop;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        r = reserve_or_release(o.action, o.start, o.stop);
        pending_replies.push_back(o.typed ? o.want : r);
        @(negedge clk);
        pace_sender();
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                         $time, rsp.outcome, rsp.slot, rsp.entries_held);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("outcome", 32'(want.outcome), 32'(rsp.outcome));
                check_field("slot", 32'(want.slot), 32'(rsp.slot));
                check_field("entries_held", 32'(want.held), 32'(rsp.entries_held));
            end
        end
    end

    // result side stalls follow a mode that changes every so often
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(10, 150);
        end
        else
            ready_left--;
        case (ready_mode)
            0:       rsp.ready <= 1'b1;
            1:       rsp.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= ((ready_left % 8) < 5);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int insert_pct;
        int phase_left;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.action     = sirt_pkg::ACT_INSERT;
        req.begin_time = '0;
        req.end_time   = '0;
        tbl_count      = 0;
        insert_pct     = 30;
        phase_left     = 0;
        load_directed();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_rows[i])
            send_op(directed_rows[i]);
        // alternate filling and draining phases so the table reaches full and empty
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (phase_left == 0)
            begin
                insert_pct = (insert_pct > 50) ? 30 : 80;
                phase_left = $urandom_range(30, 90);
            end
            else
                phase_left--;
            send_op(random_op(insert_pct));
        end
        req.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: sorted_interval_reservation_table_unit.f
rtl/sirt_pkg.sv
rtl/sirt_ifs.sv
rtl/sirt_cell.sv
rtl/sorted_interval_reservation_table_unit.sv
dv/tb.sv
